@@ sv/srb_pkg.sv @@
// Package for the sequence reorder buffer: sizes, register map, beat and slot types.
// No dependencies; used by every module of the block.
package srb_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int NUM_W  = 16;
  localparam int TAG_W  = 16;
  localparam int WIN_W  = 5;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [0:0] REG_WINDOW = 1'b0;

  typedef struct packed {
    logic [NUM_W-1:0] packet_num;
    logic             crc_good;
    logic [TAG_W-1:0] packet_tag;
  } in_beat_t;

  typedef struct packed {
    logic [TAG_W-1:0] out_tag;
    logic [NUM_W-1:0] out_num;
    logic             last;
  } out_beat_t;

  typedef struct packed {
    logic             full;
    logic [TAG_W-1:0] tag;
    logic [NUM_W-1:0] num;
  } slot_t;

  typedef struct packed {
    logic             pop;
    logic             wr;
    logic [IDX_W-1:0] wr_idx;
    logic [TAG_W-1:0] wr_tag;
    logic [NUM_W-1:0] wr_num;
  } chain_ctl_t;

endpackage

@@ sv/sequence_reorder_buffer_top.sv @@
// Top level of the sequence reorder buffer: APB register, sequencer, output stage.
// Depends on srb_pkg and srb_chain.
//
//   channel  | signals                            | direction
//   ---------+------------------------------------+----------
//   input    | in_valid, in_stall, in_data        | in / in_stall out
//   output   | out_valid, out_stall, out_data     | out / out_stall in
//   config   | psel penable pwrite paddr pwdata   | in / prdata pready out
//
// A good packet passes S_CLASS, S_AHEAD or S_FLUSH (stored ahead or on a restart),
// S_DRAIN and S_FINISH, popping at most DEPTH slots, one pop per cycle while the
// output can take a full slot; pass-through uses S_PASS; bad CRC beats are dropped.
// Reset (rst, synchronous) empties the ring; window 0, newest number 65535.
// One packet is worked on at a time; in_stall is high until its work is done.
// A stalled output holds the sequencer only when a further beat must be sent.
module sequence_reorder_buffer_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  srb_pkg::in_beat_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output srb_pkg::out_beat_t               out_data,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [srb_pkg::ADDR_W-1:0]       paddr,
  input  logic [srb_pkg::DATA_W-1:0]       pwdata,
  output logic [srb_pkg::DATA_W-1:0]       prdata,
  output logic                             pready
);
  import srb_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLASS  = 3'd1;
  localparam logic [2:0] S_AHEAD  = 3'd2;
  localparam logic [2:0] S_FLUSH  = 3'd3;
  localparam logic [2:0] S_DRAIN  = 3'd4;
  localparam logic [2:0] S_PASS   = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]       state, state_next;
  logic [WIN_W-1:0] window;
  logic [CNT_W-1:0] fill, fill_next;
  logic [NUM_W-1:0] newest, newest_next;
  logic [NUM_W-1:0] pkt_num;
  logic [TAG_W-1:0] pkt_tag;
  logic [CNT_W-1:0] gap, gap_next;

  logic             hold_valid;
  logic [TAG_W-1:0] hold_tag;
  logic [NUM_W-1:0] hold_num;

  chain_ctl_t       ctl;
  slot_t            front;

  logic             out_free, can_emit, emit_en, finish_en;
  logic [TAG_W-1:0] emit_tag;
  logic [NUM_W-1:0] emit_num;

  logic [CNT_W-1:0] w_sat;
  logic [NUM_W-1:0] diff, mag;
  logic             neg, is_ahead, is_retx, is_far;
  logic [CNT_W:0]   ahead_sum;
  logic             wr_sel;

  // config port
  assign pready = 1'b1;
  assign wr_sel = (paddr[ADDR_W-1:ADDR_W-1] == REG_WINDOW);
  assign prdata = wr_sel ? DATA_W'(window) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (psel && penable && pwrite && pready && wr_sel) begin
      window <= pwdata[WIN_W-1:0];
    end
  end

  // classification
  always_comb begin
    w_sat     = (32'(window) > 32'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(window);
    diff      = pkt_num - newest;
    neg       = diff[NUM_W-1];
    mag       = neg ? (~diff + NUM_W'(1)) : diff;
    is_ahead  = !neg && (diff != '0) && (diff < NUM_W'(w_sat));
    is_retx   = (neg || (diff == '0)) && (mag < NUM_W'(fill));
    is_far    = (mag >= NUM_W'(w_sat));
    ahead_sum = {1'b0, fill} + {1'b0, gap};
  end

  assign out_free = !out_valid || !out_stall;
  assign can_emit = !hold_valid || out_free;
  assign in_stall = (state != S_IDLE);

  // sequencer
  always_comb begin
    state_next  = state;
    fill_next   = fill;
    newest_next = newest;
    gap_next    = gap;
    emit_en     = 1'b0;
    emit_tag    = front.tag;
    emit_num    = front.num;
    finish_en   = 1'b0;
    ctl         = '0;
    ctl.wr_tag  = pkt_tag;
    ctl.wr_num  = pkt_num;

    case (state)
      S_IDLE: begin
        if (in_valid && in_data.crc_good) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        gap_next = diff[CNT_W-1:0];
        if (w_sat == '0) begin
          state_next = S_PASS;
        end else if (is_ahead) begin
          state_next = S_AHEAD;
        end else if (is_retx) begin
          ctl.wr     = 1'b1;
          ctl.wr_idx = IDX_W'(fill - CNT_W'(1) - mag[CNT_W-1:0]);
          state_next = S_DRAIN;
        end else if (is_far) begin
          state_next = S_FLUSH;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_AHEAD: begin
        if ((fill != '0) && (ahead_sum >= {1'b0, w_sat})) begin
          if (!front.full || can_emit) begin
            ctl.pop   = 1'b1;
            emit_en   = front.full;
            fill_next = fill - CNT_W'(1);
          end
        end else begin
          fill_next   = ahead_sum[CNT_W-1:0];
          ctl.wr      = 1'b1;
          ctl.wr_idx  = IDX_W'(ahead_sum - (CNT_W+1)'(1));
          newest_next = pkt_num;
          state_next  = S_DRAIN;
        end
      end
      S_FLUSH: begin
        if (fill != '0) begin
          if (!front.full || can_emit) begin
            ctl.pop   = 1'b1;
            emit_en   = front.full;
            fill_next = fill - CNT_W'(1);
          end
        end else begin
          fill_next   = CNT_W'(1);
          ctl.wr      = 1'b1;
          ctl.wr_idx  = '0;
          newest_next = pkt_num;
          state_next  = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if ((fill != '0) && front.full) begin
          if (can_emit) begin
            ctl.pop   = 1'b1;
            emit_en   = 1'b1;
            fill_next = fill - CNT_W'(1);
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_PASS: begin
        if (can_emit) begin
          emit_en    = 1'b1;
          emit_tag   = pkt_tag;
          emit_num   = pkt_num;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!hold_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          finish_en  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      newest <= '1;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      newest <= newest_next;
    end
  end

  always_ff @(posedge clk) begin
    gap <= gap_next;
    if (state == S_IDLE) begin
      pkt_num <= in_data.packet_num;
      pkt_tag <= in_data.packet_tag;
    end
  end

  srb_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .front (front)
  );

  // one-beat hold so the final beat of a packet can be marked last
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (emit_en) begin
        hold_valid <= 1'b1;
      end else if (finish_en) begin
        hold_valid <= 1'b0;
      end
      if ((emit_en && hold_valid) || finish_en) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      hold_tag <= emit_tag;
      hold_num <= emit_num;
    end
    if ((emit_en && hold_valid) || finish_en) begin
      out_data <= '{out_tag: hold_tag, out_num: hold_num, last: finish_en};
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_idle_hold_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_valid)
    else $error("held beat left over at idle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (fill != '0) && !ctl.wr)
    else $error("pop from empty ring or with store");

  a_pop_state: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (state == S_AHEAD) || (state == S_FLUSH) || (state == S_DRAIN))
    else $error("pop outside flush states");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    ((emit_en && hold_valid) || finish_en) |-> out_free)
    else $error("output beat overwritten");

endmodule

@@ sv/srb_cell.sv @@
// One slot of the reorder chain: shifts toward the head on a pop, or takes a store.
// Depends on srb_pkg.
module srb_cell (
  input  logic               clk,
  input  logic               rst,
  input  srb_pkg::chain_ctl_t ctl,
  input  logic               sel,
  input  srb_pkg::slot_t     nbr,
  output srb_pkg::slot_t     slot
);
  import srb_pkg::*;

  logic             full;
  logic [TAG_W-1:0] tag;
  logic [NUM_W-1:0] num;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (ctl.pop) begin
      full <= nbr.full;
    end else if (sel) begin
      full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      tag <= nbr.tag;
      num <= nbr.num;
    end else if (sel) begin
      tag <= ctl.wr_tag;
      num <= ctl.wr_num;
    end
  end

  assign slot = '{full: full, tag: tag, num: num};

endmodule

@@ sv/srb_chain.sv @@
// Row of DEPTH slot cells, cell 0 is the oldest; a pop shifts the row by one.
// Depends on srb_pkg and srb_cell.
module srb_chain (
  input  logic               clk,
  input  logic               rst,
  input  srb_pkg::chain_ctl_t ctl,
  output srb_pkg::slot_t     front
);
  import srb_pkg::*;

  slot_t slots [DEPTH];
  slot_t nbrs  [DEPTH];
  logic  sels  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_end
      assign nbrs[i] = '0;
    end else begin : g_mid
      assign nbrs[i] = slots[i+1];
    end
    assign sels[i] = ctl.wr && (ctl.wr_idx == IDX_W'(i));

    srb_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .sel  (sels[i]),
      .nbr  (nbrs[i]),
      .slot (slots[i])
    );
  end

  assign front = slots[0];

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for sequence_reorder_buffer_top: in-order delivery of packet handles.
// Scoreboards every output beat against a behavioral reorder ring; needs srb_pkg and the RTL.
module testbench;
  import srb_pkg::*;

  localparam int SETTLE = 2 * DEPTH + 8;
  localparam logic [ADDR_W-1:0] WINDOW_ADDR = ADDR_W'({REG_WINDOW, 2'b00});
  localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(3'b100);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  sequence_reorder_buffer_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  in_beat_t pkt_queue [$];
  out_beat_t due_beats [$];
  int in_idle_pct = 9;
  int out_idle_pct = 82;
  int errors = 0;
  int beats_seen = 0;
  int pkts_pushed = 0;
  logic [15:0] seq_base;

  // reorder ring mirror
  logic [WIN_W-1:0] win_cfg = '0;
  bit ring_full [DEPTH];
  logic [TAG_W-1:0] ring_tag [DEPTH];
  logic [NUM_W-1:0] ring_num [DEPTH];
  int ring_head = 0;
  int ring_fill = 0;
  logic [NUM_W-1:0] newest_seq = 16'hFFFF;
  out_beat_t held_beat;
  bit held_valid = 1'b0;

  initial begin
    for (int i = 0; i < DEPTH; i++) ring_full[i] = 1'b0;
  end

  task automatic ring_deliver(input logic [TAG_W-1:0] tag, input logic [NUM_W-1:0] num);
    if (held_valid) due_beats.insert(due_beats.size(), held_beat);
    held_beat.out_tag = tag;
    held_beat.out_num = num;
    held_beat.last = 1'b0;
    held_valid = 1'b1;
  endtask

  task automatic ring_pop();
    if (ring_full[ring_head]) ring_deliver(ring_tag[ring_head], ring_num[ring_head]);
    ring_full[ring_head] = 1'b0;
    ring_head = (ring_head + 1) % DEPTH;
    ring_fill--;
  endtask

  task automatic ring_put(input int k, input logic [NUM_W-1:0] num,
                          input logic [TAG_W-1:0] tag);
    int p;
    p = (ring_head + k) % DEPTH;
    ring_full[p] = 1'b1;
    ring_tag[p] = tag;
    ring_num[p] = num;
  endtask

  task automatic reorder_predict(input in_beat_t b);
    int w;
    int d;
    int mag;
    logic [15:0] diff;
    if (!b.crc_good) return;
    w = (int'(win_cfg) > DEPTH) ? DEPTH : int'(win_cfg);
    if (w == 0) begin
      ring_deliver(b.packet_tag, b.packet_num);
    end else begin
      diff = b.packet_num - newest_seq;
      d = diff[15] ? int'(diff) - 65536 : int'(diff);
      mag = (d < 0) ? -d : d;
      if (d > 0 && d < w) begin
        while (ring_fill > 0 && ring_fill + d >= w) ring_pop();
        ring_fill += d;
        ring_put(ring_fill - 1, b.packet_num, b.packet_tag);
        newest_seq = b.packet_num;
      end else if (d <= 0 && mag < ring_fill) begin
        ring_put(ring_fill - 1 - mag, b.packet_num, b.packet_tag);
      end else if (mag >= w) begin
        while (ring_fill > 0) ring_pop();
        ring_fill = 1;
        ring_put(0, b.packet_num, b.packet_tag);
        newest_seq = b.packet_num;
      end
      while (ring_fill > 0 && ring_full[ring_head]) ring_pop();
    end
    if (held_valid) begin
      held_beat.last = 1'b1;
      due_beats.insert(due_beats.size(), held_beat);
      held_valid = 1'b0;
    end
  endtask

  task automatic flag(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin : drive_p
    logic take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = in_valid && !in_stall;
      if (take) reorder_predict(in_data);
      if (!in_valid || take) begin
        if (pkt_queue.size() > 0 && $urandom_range(99, 0) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pkt_queue[0];
          pkt_queue.delete(0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : mon_p
    out_beat_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        beats_seen++;
        if (due_beats.size() == 0) begin
          flag($sformatf("beat %0d: unexpected, got tag %h num %h last %b",
                         beats_seen, out_data.out_tag, out_data.out_num, out_data.last));
        end else begin
          want = due_beats[0];
          due_beats.delete(0);
          if (out_data.out_tag !== want.out_tag || out_data.out_num !== want.out_num ||
              out_data.last !== want.last)
            flag($sformatf("beat %0d: expected tag %h num %h last %b, got tag %h num %h last %b",
                           beats_seen, want.out_tag, want.out_num, want.last,
                           out_data.out_tag, out_data.out_num, out_data.last));
        end
      end
      out_stall <= ($urandom_range(99, 0) < out_idle_pct);
    end
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == WINDOW_ADDR) win_cfg = data[WIN_W-1:0];
    @(negedge clk);
    if (addr == WINDOW_ADDR && prdata !== DATA_W'(data[WIN_W-1:0]))
      flag($sformatf("window readback: expected %h, got %h", data[WIN_W-1:0], prdata));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pkt_queue.size() != 0 || in_valid || due_beats.size() != 0 || in_stall)
      @(negedge clk);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_pkt(input logic [15:0] num, input bit good, input logic [15:0] tag);
    in_beat_t b;
    b.packet_num = num;
    b.crc_good = good;
    b.packet_tag = tag;
    pkt_queue.insert(pkt_queue.size(), b);
    pkts_pushed++;
  endtask

  // run of consecutive numbers, lightly shuffled, with gaps, resends and bad CRCs
  task automatic push_burst();
    logic [15:0] seqs [8];
    logic [15:0] t;
    int k;
    int j;
    k = $urandom_range(8, 1);
    for (j = 0; j < k; j++) seqs[j] = seq_base + 16'(j);
    for (j = 0; j < k - 1; j++) begin
      if ($urandom_range(99, 0) < 40) begin
        t = seqs[j];
        seqs[j] = seqs[j + 1];
        seqs[j + 1] = t;
      end
    end
    for (j = 0; j < k; j++) begin
      if ($urandom_range(99, 0) < 6) continue;
      push_pkt(seqs[j], $urandom_range(99, 0) >= 4, 16'($urandom));
      if ($urandom_range(99, 0) < 8) push_pkt(seqs[$urandom_range(j, 0)], 1'b1, 16'($urandom));
    end
    seq_base += 16'(k);
  endtask

  task automatic gen_random(input int count);
    int target;
    int r;
    target = pkts_pushed + count;
    while (pkts_pushed < target) begin
      r = $urandom_range(99, 0);
      if (r < 70) begin
        push_burst();
      end else if (r < 78) begin
        push_pkt(16'($urandom), 1'b1, 16'($urandom));
      end else if (r < 86) begin
        push_pkt(16'($urandom), 1'b0, 16'($urandom));
      end else if (r < 93) begin
        seq_base += 16'($urandom_range(40000, 8));
        push_burst();
      end else begin
        push_pkt(seq_base - 16'($urandom_range(40, 1)), 1'b1, 16'($urandom));
      end
    end
  endtask

  initial begin : stim
    int ph;
    int win_plan [8];
    win_plan = '{16, 5, 0, 9, 31, 1, 12, 0};
    win_plan[7] = $urandom_range(15, 2);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // pass-through, field extremes, bad CRC
    apb_write(WINDOW_ADDR, 0);
    @(negedge clk);
    push_pkt(16'h0000, 1'b1, 16'h0000);
    push_pkt(16'hFFFF, 1'b1, 16'hFFFF);
    push_pkt(16'h1234, 1'b0, 16'hABCD);
    push_pkt(16'h8000, 1'b1, 16'h5555);
    // write to an unmapped register leaves the window at 0
    wait_idle();
    apb_write(SPARE_ADDR, 7);
    @(negedge clk);
    push_pkt(16'h0007, 1'b1, 16'($urandom));

    // full window: gaps, resends, drops, flush of empty slots, far jumps, wrap
    wait_idle();
    apb_write(WINDOW_ADDR, DEPTH);
    @(negedge clk);
    push_pkt(16'd0, 1'b1, 16'($urandom));
    push_pkt(16'd2, 1'b1, 16'($urandom));
    push_pkt(16'd3, 1'b1, 16'($urandom));
    push_pkt(16'd1, 1'b1, 16'($urandom));
    push_pkt(16'd3, 1'b1, 16'($urandom));
    push_pkt(16'hFFFF, 1'b1, 16'($urandom));
    push_pkt(16'd10, 1'b1, 16'($urandom));
    push_pkt(16'd12, 1'b1, 16'($urandom));
    push_pkt(16'd14, 1'b1, 16'($urandom));
    push_pkt(16'd13, 1'b1, 16'($urandom));
    push_pkt(16'd26, 1'b1, 16'($urandom));
    push_pkt(16'd11, 1'b1, 16'($urandom));
    push_pkt(16'd60, 1'b1, 16'($urandom));
    push_pkt(16'd61, 1'b0, 16'($urandom));
    push_pkt(16'hFFFE, 1'b1, 16'($urandom));
    push_pkt(16'd1, 1'b1, 16'($urandom));
    push_pkt(16'd0, 1'b1, 16'($urandom));
    push_pkt(16'hFFFF, 1'b1, 16'($urandom));

    // window above depth saturates
    wait_idle();
    apb_write(WINDOW_ADDR, 31);
    @(negedge clk);
    push_pkt(16'd30, 1'b1, 16'($urandom));
    push_pkt(16'd45, 1'b1, 16'($urandom));
    push_pkt(16'd31, 1'b1, 16'($urandom));
    push_pkt(16'd46, 1'b1, 16'($urandom));

    // smallest window
    wait_idle();
    apb_write(WINDOW_ADDR, 1);
    @(negedge clk);
    push_pkt(16'd47, 1'b1, 16'($urandom));
    push_pkt(16'd47, 1'b1, 16'($urandom));
    push_pkt(16'd48, 1'b1, 16'($urandom));

    for (ph = 0; ph < 8; ph++) begin
      wait_idle();
      apb_write(WINDOW_ADDR, win_plan[ph]);
      @(negedge clk);
      if (ph < 3) begin
        in_idle_pct = 9;
        out_idle_pct = 82;
      end else if (ph < 6) begin
        in_idle_pct = 82;
        out_idle_pct = 9;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      seq_base = newest_seq + 16'd1;
      if (ph == 1) begin
        gen_random(28);
        wait_drained();
        gen_random(28);
      end else begin
        gen_random(56);
      end
    end

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
